// ----- rtl/multi_key_click_long_press_detector_macros.svh -----
// Assertion macros shared by the detector's RTL files.
// MKCLP_ASSERT samples on the rising edge of clk and is disabled during reset.
// MKCLP_ASSERT_RST samples on the rising edge of clk and stays active in reset.
`ifndef MULTI_KEY_CLICK_LONG_PRESS_DETECTOR_MACROS_SVH
`define MULTI_KEY_CLICK_LONG_PRESS_DETECTOR_MACROS_SVH

`ifndef SYNTHESIS

`define MKCLP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define MKCLP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define MKCLP_ASSERT(lbl, prop, msg)

`define MKCLP_ASSERT_RST(lbl, prop, msg)

`endif

`endif

// ----- rtl/mkclp_pkg.sv -----
package mkclp_pkg;

  // Width of the pin, mask and event fields.
  localparam int unsigned FIELD_W = 5;
  // Width of the hold counter and of the long-press threshold.
  localparam int unsigned CNT_W = 8;

  localparam int unsigned NUM_KEYS_DEF = 5;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_LEVEL = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_TICKS  = CFG_IDX_W'(1);

  localparam logic [FIELD_W-1:0] PRESS_LEVEL_RST = FIELD_W'(4);
  localparam logic [CNT_W-1:0]   LONG_TICKS_RST  = CNT_W'(70);

  // Release events of one key for the current transaction.
  typedef struct packed {
    logic click;
    logic long_rel;
  } key_evt_t;

endpackage

// ----- rtl/mkclp_lane.sv -----
`include "multi_key_click_long_press_detector_macros.svh"

module mkclp_lane (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step_en,
  input  logic                       pressed,
  input  logic [mkclp_pkg::CNT_W-1:0] thresh,
  output mkclp_pkg::key_evt_t        evt
);
  import mkclp_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_DEBOUNCE,
    PH_PRESS,
    PH_LONG
  } phase_t;

  phase_t           phase_r;
  phase_t           phase_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  always_comb begin
    phase_nxt    = phase_r;
    count_nxt    = count_r;
    evt.click    = 1'b0;
    evt.long_rel = 1'b0;
    if (step_en) begin
      unique case (phase_r)
        PH_IDLE: begin
          if (pressed) begin
            phase_nxt = PH_DEBOUNCE;
          end
        end
        PH_DEBOUNCE: begin
          phase_nxt = pressed ? PH_PRESS : PH_IDLE;
        end
        PH_PRESS: begin
          if (pressed) begin
            // The counter has already reached the threshold, so this tick
            // starts the long press.
            if (count_r >= thresh) begin
              count_nxt = '0;
              phase_nxt = PH_LONG;
            end else begin
              count_nxt = count_r + CNT_W'(1);
            end
          end else begin
            count_nxt = '0;
            phase_nxt = PH_IDLE;
            evt.click = 1'b1;
          end
        end
        PH_LONG: begin
          if (!pressed) begin
            phase_nxt    = PH_IDLE;
            evt.long_rel = 1'b1;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      count_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
    end
  end

  `MKCLP_ASSERT(a_cnt_only_in_press, (phase_r != PH_PRESS) |-> (count_r == '0), "hold count nonzero outside confirmed press")
  `MKCLP_ASSERT(a_click_to_idle, evt.click |=> (phase_r == PH_IDLE), "click did not return the key to idle")
  `MKCLP_ASSERT(a_long_holds, (step_en && phase_r == PH_LONG && pressed) |=> (phase_r == PH_LONG && count_r == '0), "long press left while held")

endmodule

// ----- rtl/mkclp_merge.sv -----
`include "multi_key_click_long_press_detector_macros.svh"

module mkclp_merge #(
  parameter int unsigned NUM_KEYS = mkclp_pkg::NUM_KEYS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  accept,
  input  mkclp_pkg::key_evt_t [NUM_KEYS-1:0]    evt,
  output logic                                  in_stall,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [mkclp_pkg::FIELD_W-1:0]         out_click_mask,
  output logic [mkclp_pkg::FIELD_W-1:0]         out_long_press_mask
);
  import mkclp_pkg::*;

  logic [FIELD_W-1:0] click_m;
  logic [FIELD_W-1:0] long_m;

  logic               main_vld_r;
  logic               main_vld_nxt;
  logic [FIELD_W-1:0] main_click_r;
  logic [FIELD_W-1:0] main_click_nxt;
  logic [FIELD_W-1:0] main_long_r;
  logic [FIELD_W-1:0] main_long_nxt;
  logic               skid_vld_r;
  logic               skid_vld_nxt;
  logic [FIELD_W-1:0] skid_click_r;
  logic [FIELD_W-1:0] skid_click_nxt;
  logic [FIELD_W-1:0] skid_long_r;
  logic [FIELD_W-1:0] skid_long_nxt;
  logic               take;

  // Keys above the field width have no place in the result masks.
  for (genvar gi = 0; gi < FIELD_W; gi++) begin : g_bit
    if (gi < NUM_KEYS) begin : g_key
      assign click_m[gi] = evt[gi].click;
      assign long_m[gi]  = evt[gi].long_rel;
    end else begin : g_none
      assign click_m[gi] = 1'b0;
      assign long_m[gi]  = 1'b0;
    end
  end

  assign take = main_vld_r && !out_stall;

  always_comb begin
    main_vld_nxt   = main_vld_r;
    main_click_nxt = main_click_r;
    main_long_nxt  = main_long_r;
    skid_vld_nxt   = skid_vld_r;
    skid_click_nxt = skid_click_r;
    skid_long_nxt  = skid_long_r;
    if (!main_vld_r || take) begin
      if (skid_vld_r) begin
        main_vld_nxt   = 1'b1;
        main_click_nxt = skid_click_r;
        main_long_nxt  = skid_long_r;
        skid_vld_nxt   = 1'b0;
      end else begin
        main_vld_nxt   = accept;
        main_click_nxt = click_m;
        main_long_nxt  = long_m;
      end
    end else if (accept) begin
      // Output is held, so the new transaction parks in the skid stage.
      skid_vld_nxt   = 1'b1;
      skid_click_nxt = click_m;
      skid_long_nxt  = long_m;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      main_vld_r <= main_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
    main_click_r <= main_click_nxt;
    main_long_r  <= main_long_nxt;
    skid_click_r <= skid_click_nxt;
    skid_long_r  <= skid_long_nxt;
  end

  assign in_stall            = skid_vld_r;
  assign out_valid           = main_vld_r;
  assign out_click_mask      = main_click_r;
  assign out_long_press_mask = main_long_r;

  `MKCLP_ASSERT(a_skid_needs_main, skid_vld_r |-> main_vld_r, "skid stage full while output stage empty")
  `MKCLP_ASSERT(a_skid_fill, $rose(skid_vld_r) |-> $past(main_vld_r && out_stall && accept), "skid filled without a held output")
  `MKCLP_ASSERT(a_drain, (take && !skid_vld_r && !accept) |=> !main_vld_r, "result repeated after it was taken")
  `MKCLP_ASSERT_RST(a_rst_empty, !rst_n |=> (!main_vld_r && !skid_vld_r), "buffers not empty after reset")

endmodule

// ----- rtl/multi_key_click_long_press_detector.sv -----
// Channel | Direction | Handshake          | Payload
// in_     | input     | in_valid/in_stall  | in_pin_levels[4:0]
// out_    | output    | out_valid/out_stall| out_click_mask[4:0], out_long_press_mask[4:0]
// cfg_    | input     | cfg_valid/cfg_ready| cfg_index[1:0], cfg_data[7:0]
//
// One transaction per cycle while in_stall is low: every key lane updates its phase and
// counter in the accept cycle; the result is registered in the output or the skid stage.
// A two-entry output buffer (output register plus skid stage) sets the throughput;
// in_stall rises only when both entries hold results that have not been taken.
// Reset is synchronous and active low; configuration is always ready.
`include "multi_key_click_long_press_detector_macros.svh"

module multi_key_click_long_press_detector #(
  parameter int unsigned NUM_KEYS = mkclp_pkg::NUM_KEYS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [mkclp_pkg::FIELD_W-1:0]       in_pin_levels,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [mkclp_pkg::FIELD_W-1:0]       out_click_mask,
  output logic [mkclp_pkg::FIELD_W-1:0]       out_long_press_mask,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mkclp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mkclp_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import mkclp_pkg::*;

  logic [FIELD_W-1:0]          press_level_mask_r;
  logic [CNT_W-1:0]            long_press_ticks_r;
  logic                        accept;
  logic [NUM_KEYS-1:0]         pressed;
  key_evt_t [NUM_KEYS-1:0]     evt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_level_mask_r <= PRESS_LEVEL_RST;
      long_press_ticks_r <= LONG_TICKS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PRESS_LEVEL: press_level_mask_r <= cfg_data[FIELD_W-1:0];
        CFG_LONG_TICKS:  long_press_ticks_r <= cfg_data[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign accept = in_valid && !in_stall;

  for (genvar gk = 0; gk < NUM_KEYS; gk++) begin : g_lane
    // Keys above the field width have no pin and are tied to pressed.
    if (gk < FIELD_W) begin : g_pin
      assign pressed[gk] = (in_pin_levels[gk] == press_level_mask_r[gk]);
    end else begin : g_const
      assign pressed[gk] = 1'b1;
    end

    mkclp_lane u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .step_en (accept),
      .pressed (pressed[gk]),
      .thresh  (long_press_ticks_r),
      .evt     (evt[gk])
    );
  end

  mkclp_merge #(
    .NUM_KEYS (NUM_KEYS)
  ) u_merge (
    .clk                 (clk),
    .rst_n               (rst_n),
    .accept              (accept),
    .evt                 (evt),
    .in_stall            (in_stall),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_click_mask      (out_click_mask),
    .out_long_press_mask (out_long_press_mask)
  );

  `MKCLP_ASSERT(a_no_double_event, (out_valid) |-> ((out_click_mask & out_long_press_mask) == '0), "key flagged as click and long press at once")
  `MKCLP_ASSERT(a_accept_fills, accept |=> out_valid, "accepted transaction produced no result")
  `MKCLP_ASSERT(a_cfg_takes, (cfg_valid && cfg_index == CFG_LONG_TICKS) |=> (long_press_ticks_r == $past(cfg_data[CNT_W-1:0])), "threshold write lost")

endmodule
